// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication form
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/orc_pkg.sv =====
package orc_pkg;
  localparam int COORD_BITS = 20;
  localparam int MAX_OBSTACLES = 4096;
  localparam int ID_BITS = 13;
  localparam int CNT_BITS = 13;
  localparam int NPAT = 4;
  localparam logic [CNT_BITS-1:0] CNT_MAX =
    (MAX_OBSTACLES > 8191) ? CNT_BITS'(8191) : CNT_BITS'(MAX_OBSTACLES);
  // signed working width: coordinates plus headroom for sums
  localparam int SW = COORD_BITS + 3;
  typedef logic signed [SW-1:0] sc_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
endpackage

// ===== src/orc_pattern.sv =====
module orc_pattern (
  input  logic [1:0]      pat,
  input  orc_pkg::coord_t x1,
  input  orc_pkg::coord_t y1,
  input  orc_pkg::coord_t x2,
  input  orc_pkg::coord_t y2,
  input  orc_pkg::coord_t rl,
  input  orc_pkg::coord_t rb,
  input  orc_pkg::coord_t rr,
  input  orc_pkg::coord_t rt,
  output logic            hit
);
  import orc_pkg::*;

  sc_t sx1, sy1, sx2, sy2, L, B, R, T;
  sc_t fx, fy, l, r, b, t;
  sc_t ax, ay, bx, by, d;
  sc_t hpos, hs, he, vpos, vs, ve, dsx, dsy, dex, dey;
  sc_t ylo, yhi, sg_dy;
  sc_t cx [4];
  sc_t cy [4];
  logic [3:0] ok;
  logic hv, vv, dv, m, neg, in_s, in_e, diag;
  logic [2:0] n;
  sc_t p0x, p0y, p1x, p1y;

  always_comb begin
    sx1 = sc_t'(x1); sy1 = sc_t'(y1); sx2 = sc_t'(x2); sy2 = sc_t'(y2);
    L = sc_t'(rl); B = sc_t'(rb); R = sc_t'(rr); T = sc_t'(rt);
    fx = (sx1 > sx2) ? sx1 - sx2 : sx2 - sx1;
    fy = (sy1 > sy2) ? sy1 - sy2 : sy2 - sy1;
    l = (sx1 < sx2) ? sx1 : sx2; r = (sx1 < sx2) ? sx2 : sx1;
    b = (sy1 < sy2) ? sy1 : sy2; t = (sy1 < sy2) ? sy2 : sy1;
    hv = 1'b0; vv = 1'b0; dv = 1'b0;
    hpos = '0; hs = '0; he = '0; vpos = '0; vs = '0; ve = '0;
    dsx = '0; dsy = '0; dex = '0; dey = '0;
    ax = sx1; ay = sy1; bx = sx2; by = sy2; m = pat[0]; d = '0;
    if (pat[1] || fx == '0 || fy == '0) begin
      hv = 1'b1; vv = 1'b1;
      hs = l; he = r; vs = b; ve = t;
      if (!pat[1]) begin
        hpos = pat[0] ? sy2 : sy1;
        vpos = pat[0] ? sx2 : sx1;
      end else begin
        hpos = pat[0] ? sy1 : sy2;   // pattern 3 corners at (x2,y1)
        vpos = pat[0] ? sx2 : sx1;
      end
    end else begin
      if (sx1 > sx2) begin
        ax = sx2; ay = sy2; bx = sx1; by = sy1; m = ~pat[0];
      end
      dv = 1'b1;
      if (fx > fy) begin
        d = fy; hv = 1'b1;
        if (!m) begin
          hpos = ay; hs = ax; he = bx - d;
          dsx = bx - d; dsy = ay; dex = bx; dey = by;
        end else begin
          hpos = by; hs = ax + d; he = bx;
          dsx = ax; dsy = ay; dex = ax + d; dey = by;
        end
      end else begin
        d = fx; vv = 1'b1;
        if (!m) begin
          vpos = ax; dsx = ax; dex = bx; dey = by;
          if (ay < by) begin dsy = by - d; vs = ay; ve = by - d; end
          else begin dsy = by + d; vs = by + d; ve = ay; end
        end else begin
          vpos = bx; dsx = ax; dsy = ay; dex = bx;
          if (ay < by) begin dey = ay + d; vs = ay + d; ve = by; end
          else begin dey = ay - d; vs = by; ve = ay - d; end
        end
      end
    end

    // diagonal crossings of the four rectangle edges
    neg = !(dey > dsy);
    ylo = (dsy < dey) ? dsy : dey;
    yhi = (dsy < dey) ? dey : dsy;
    in_s = dsx > L && dsx < R && dsy > B && dsy < T;
    in_e = dex > L && dex < R && dey > B && dey < T;
    for (int i = 0; i < 2; i++) begin
      cy[i] = (i == 0) ? B : T;
      sg_dy = cy[i] - dsy;
      cx[i] = neg ? dsx - sg_dy : dsx + sg_dy;
      ok[i] = cx[i] >= L && cx[i] <= R && cx[i] >= dsx && cx[i] <= dex;
    end
    for (int i = 2; i < 4; i++) begin
      cx[i] = (i == 2) ? L : R;
      sg_dy = cx[i] - dsx;
      cy[i] = neg ? dsy - sg_dy : dsy + sg_dy;
      ok[i] = cy[i] >= B && cy[i] <= T && cy[i] >= ylo && cy[i] <= yhi;
    end
    n = 3'($countones(ok));
    // first two accepted crossings in index order
    p0x = '0; p0y = '0; p1x = '0; p1y = '0;
    priority if (ok[0]) begin
      p0x = cx[0]; p0y = cy[0];
      priority if (ok[1]) begin p1x = cx[1]; p1y = cy[1]; end
      else if (ok[2]) begin p1x = cx[2]; p1y = cy[2]; end
      else begin p1x = cx[3]; p1y = cy[3]; end
    end else if (ok[1]) begin
      p0x = cx[1]; p0y = cy[1];
      priority if (ok[2]) begin p1x = cx[2]; p1y = cy[2]; end
      else begin p1x = cx[3]; p1y = cy[3]; end
    end else begin
      p0x = cx[2]; p0y = cy[2]; p1x = cx[3]; p1y = cy[3];
    end
    diag = in_s || in_e || n >= 3'd3 ||
           (n == 3'd2 && !(p0x == p1x && p0y == p1y));

    if (L >= r || B >= t || R <= l || T <= b) hit = 1'b0;
    else if (hv && !(hpos <= B || hpos >= T || he <= L || hs >= R)) hit = 1'b1;
    else if (vv && !(vpos <= L || vpos >= R || ve <= B || vs >= T)) hit = 1'b1;
    else hit = dv && diag;
  end
endmodule

// ===== src/octilinear_route_obstacle_check.sv =====
// Octilinear route obstacle check. Each item (two pins and one obstacle
// rectangle) yields one result item: the 4-bit mask of candidate routes that
// cross the obstacle's interior, running per-route hit counts (cleared by
// first_obstacle, saturating), and on last_obstacle the highest route with
// no hits. One item per clock unless the output stalls; the result appears in
// the cycle after it is taken, from one output register stage held on stall.
`include "assert_macros.svh"
module octilinear_route_obstacle_check (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  orc_pkg::coord_t in_src_x,
  input  orc_pkg::coord_t in_src_y,
  input  orc_pkg::coord_t in_dst_x,
  input  orc_pkg::coord_t in_dst_y,
  input  orc_pkg::coord_t in_rect_left,
  input  orc_pkg::coord_t in_rect_bottom,
  input  orc_pkg::coord_t in_rect_right,
  input  orc_pkg::coord_t in_rect_top,
  input  orc_pkg::id_t    in_obstacle_id,
  input  logic            in_first_obstacle,
  input  logic            in_last_obstacle,
  output logic            out_valid,
  input  logic            out_ready,
  output orc_pkg::id_t    out_echo_id,
  output logic [3:0]      out_hit_mask,
  output orc_pkg::cnt_t   out_count_p0,
  output orc_pkg::cnt_t   out_count_p1,
  output orc_pkg::cnt_t   out_count_p2,
  output orc_pkg::cnt_t   out_count_p3,
  output logic [1:0]      out_free_pattern,
  output logic            out_free_found,
  output logic            out_done_res
);
  import orc_pkg::*;

  logic [NPAT-1:0] hit;
  cnt_t cnt_r [NPAT];
  cnt_t cnt_nxt [NPAT];
  cnt_t base;
  logic [1:0] freep_nxt;
  logic freef_nxt, take, valid_r;
  id_t id_r;
  logic [3:0] mask_r;
  logic [1:0] freep_r;
  logic freef_r, done_r;

  for (genvar p = 0; p < NPAT; p++) begin : g_pat
    orc_pattern u_pat (
      .pat(2'(p)), .x1(in_src_x), .y1(in_src_y), .x2(in_dst_x), .y2(in_dst_y),
      .rl(in_rect_left), .rb(in_rect_bottom), .rr(in_rect_right),
      .rt(in_rect_top), .hit(hit[p])
    );
  end

  assign in_ready = !valid_r || out_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    freep_nxt = 2'd0;
    freef_nxt = 1'b0;
    for (int p = 0; p < NPAT; p++) begin
      base = in_first_obstacle ? '0 : cnt_r[p];
      cnt_nxt[p] = (hit[p] && base < CNT_MAX) ? base + cnt_t'(1) : base;
      if (in_last_obstacle && cnt_nxt[p] == '0) begin
        freep_nxt = 2'(p);
        freef_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int p = 0; p < NPAT; p++) cnt_r[p] <= '0;
    end else begin
      if (take) begin
        valid_r <= 1'b1;
        for (int p = 0; p < NPAT; p++) cnt_r[p] <= cnt_nxt[p];
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
    if (take) begin
      id_r <= in_obstacle_id;
      mask_r <= hit;
      freep_r <= freep_nxt;
      freef_r <= freef_nxt;
      done_r <= in_last_obstacle;
    end
  end

  assign out_valid = valid_r;
  assign out_echo_id = id_r;
  assign out_hit_mask = mask_r;
  assign out_count_p0 = cnt_r[0];
  assign out_count_p1 = cnt_r[1];
  assign out_count_p2 = cnt_r[2];
  assign out_count_p3 = cnt_r[3];
  assign out_free_pattern = freep_r;
  assign out_free_found = freef_r;
  assign out_done_res = done_r;

  `ASSERT_IMP(a_hold, valid_r && !out_ready, !in_ready, "item taken while result stalled")
  `ASSERT_IMP(a_free_last, freef_r && valid_r, done_r, "free route reported before last item")
  `ASSERT_IMP(a_cnt_sat, valid_r, cnt_r[0] <= CNT_MAX && cnt_r[3] <= CNT_MAX,
              "hit count beyond saturation")
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import orc_pkg::*;

  typedef struct {
    coord_t sx, sy, dx, dy, l, b, r, t;
    id_t    id;
    logic   first, last;
  } obst_item_t;

  typedef struct {
    id_t        id;
    logic [3:0] mask;
    cnt_t       cnt [4];
    logic [1:0] freep;
    logic       freef, done;
  } route_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  logic in_valid = 1'b0, in_ready;
  coord_t in_src_x = '0, in_src_y = '0, in_dst_x = '0, in_dst_y = '0;
  coord_t in_rect_left = '0, in_rect_bottom = '0, in_rect_right = '0, in_rect_top = '0;
  id_t in_obstacle_id = 13'd1;
  logic in_first_obstacle = 1'b0, in_last_obstacle = 1'b0;
  logic out_valid, out_ready = 1'b0;
  id_t out_echo_id;
  logic [3:0] out_hit_mask;
  cnt_t out_count_p0, out_count_p1, out_count_p2, out_count_p3;
  logic [1:0] out_free_pattern;
  logic out_free_found, out_done_res;

  octilinear_route_obstacle_check u_top (.*);

  obst_item_t pending_q[$];
  route_res_t expected_q[$];
  cnt_t hit_cnt [4];
  int errors = 0, accepted = 0, results_seen = 0;
  bit no_idle = 0, rx_hold = 0;
  int idle_cycles = 0;
  logic in_ready_q = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got, want);
    errors++;
  endtask

  function automatic bit pt_in(longint x, longint y, longint L, longint B, longint R,
                               longint T);
    return x > L && x < R && y > B && y < T;
  endfunction

  function automatic bit diag_cross(longint sx, longint sy, longint ex, longint ey,
                                    longint L, longint B, longint R, longint T);
    longint sg, ylo, yhi, cx, cy, px0, py0, px1, py1;
    int n;
    bit ok;
    sg = (ey > sy) ? 1 : -1;
    ylo = (sy < ey) ? sy : ey;
    yhi = (sy < ey) ? ey : sy;
    n = 0; px0 = 0; py0 = 0; px1 = 0; py1 = 0;
    if (pt_in(sx, sy, L, B, R, T) || pt_in(ex, ey, L, B, R, T)) return 1;
    for (int i = 0; i < 4; i++) begin
      if (i < 2) begin
        cy = (i == 0) ? B : T;
        cx = sx + sg * (cy - sy);
        ok = cx >= L && cx <= R && cx >= sx && cx <= ex;
      end else begin
        cx = (i == 2) ? L : R;
        cy = sy + sg * (cx - sx);
        ok = cy >= B && cy <= T && cy >= ylo && cy <= yhi;
      end
      if (ok) begin
        if (n == 0) begin px0 = cx; py0 = cy; end
        else if (n == 1) begin px1 = cx; py1 = cy; end
        n++;
      end
    end
    if (n >= 3) return 1;
    return n == 2 && !(px0 == px1 && py0 == py1);
  endfunction

  function automatic bit route_blocked(int pat, longint x1, longint y1, longint x2,
                                       longint y2, longint L, longint B, longint R,
                                       longint T);
    longint fx, fy, lo_x, hi_x, lo_y, hi_y, d;
    longint hpos, hs, he, vpos, vs, ve, sx, sy, ex, ey, ax, ay, bx, by;
    bit hv, vv, dv;
    int m;
    fx = (x1 > x2) ? x1 - x2 : x2 - x1;
    fy = (y1 > y2) ? y1 - y2 : y2 - y1;
    lo_x = (x1 < x2) ? x1 : x2; hi_x = (x1 < x2) ? x2 : x1;
    lo_y = (y1 < y2) ? y1 : y2; hi_y = (y1 < y2) ? y2 : y1;
    hv = 0; vv = 0; dv = 0; m = pat;
    hpos = 0; hs = 0; he = 0; vpos = 0; vs = 0; ve = 0;
    sx = 0; sy = 0; ex = 0; ey = 0;
    if (m >= 2 || fx == 0 || fy == 0) begin
      hv = 1; vv = 1;
      hs = lo_x; he = hi_x; vs = lo_y; ve = hi_y;
      if (m < 2) begin
        hpos = (m == 0) ? y1 : y2;
        vpos = (m == 0) ? x1 : x2;
      end else begin
        hpos = (m == 3) ? y1 : y2;
        vpos = (m == 3) ? x2 : x1;
      end
    end else begin
      ax = x1; ay = y1; bx = x2; by = y2;
      if (x1 > x2) begin
        ax = x2; ay = y2; bx = x1; by = y1;
        m ^= 1;
      end
      dv = 1;
      if (fx > fy) begin
        d = fy; hv = 1;
        if (m == 0) begin
          hpos = ay; hs = ax; he = bx - d;
          sx = bx - d; sy = ay; ex = bx; ey = by;
        end else begin
          hpos = by; hs = ax + d; he = bx;
          sx = ax; sy = ay; ex = ax + d; ey = by;
        end
      end else begin
        d = fx; vv = 1;
        if (m == 0) begin
          vpos = ax; sx = ax; ex = bx; ey = by;
          if (ay < by) begin sy = by - d; vs = ay; ve = by - d; end
          else begin sy = by + d; vs = by + d; ve = ay; end
        end else begin
          vpos = bx; sx = ax; sy = ay; ex = bx;
          if (ay < by) begin ey = ay + d; vs = ay + d; ve = by; end
          else begin ey = ay - d; vs = by; ve = ay - d; end
        end
      end
    end
    if (L >= hi_x || B >= hi_y || R <= lo_x || T <= lo_y) return 0;
    if (hv && !(hpos <= B || hpos >= T || he <= L || hs >= R)) return 1;
    if (vv && !(vpos <= L || vpos >= R || ve <= B || vs >= T)) return 1;
    if (dv) return diag_cross(sx, sy, ex, ey, L, B, R, T);
    return 0;
  endfunction

  function automatic route_res_t predict_routes(obst_item_t it);
    route_res_t res;
    if (it.first) for (int p = 0; p < 4; p++) hit_cnt[p] = '0;
    res.mask = '0;
    for (int p = 0; p < 4; p++)
      if (route_blocked(p, it.sx, it.sy, it.dx, it.dy, it.l, it.b, it.r, it.t)) begin
        res.mask[p] = 1'b1;
        if (hit_cnt[p] < CNT_MAX) hit_cnt[p]++;
      end
    res.freep = '0; res.freef = 1'b0;
    if (it.last)
      for (int p = 0; p < 4; p++)
        if (hit_cnt[p] == 0) begin res.freep = p[1:0]; res.freef = 1'b1; end
    res.id = it.id;
    res.cnt = hit_cnt;
    res.done = it.last;
    return res;
  endfunction

  function automatic coord_t near_coord(coord_t c, int span);
    longint v;
    v = longint'(c) + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > 1048575) v = 1048575;
    return coord_t'(v);
  endfunction

  // one pin pair with a run of obstacles; geometry mostly kept near the pins
  task automatic add_net(int n_obst, int span, bit diag, bit mark_first);
    obst_item_t it;
    coord_t bx, by;
    int w, h;
    bx = coord_t'($urandom_range(1048575 - 4 * span));
    by = coord_t'($urandom_range(1048575 - 4 * span));
    it.sx = coord_t'(bx + $urandom_range(span));
    it.sy = coord_t'(by + $urandom_range(span));
    if (diag && ($urandom_range(1) == 1)) begin
      w = $urandom_range(span); h = $urandom_range(w);
      it.dx = coord_t'(it.sx + w);
      it.dy = coord_t'(($urandom_range(1) == 1) ? it.sy + h :
                       ((it.sy > h) ? it.sy - h : it.sy));
      if ($urandom_range(1) == 1) begin
        coord_t tmp;
        tmp = it.sx; it.sx = it.dx; it.dx = tmp;
      end
      if ($urandom_range(1) == 1) begin
        coord_t tmp;
        tmp = it.sx; it.sx = it.sy; it.sy = tmp;
        tmp = it.dx; it.dx = it.dy; it.dy = tmp;
      end
    end else begin
      it.dx = coord_t'(bx + $urandom_range(span));
      it.dy = coord_t'(by + $urandom_range(span));
      if ($urandom_range(9) == 0) it.dx = it.sx;
      if ($urandom_range(9) == 0) it.dy = it.sy;
    end
    for (int k = 0; k < n_obst; k++) begin
      it.l = near_coord(bx, span); it.b = near_coord(by, span);
      w = $urandom_range(span); h = $urandom_range(span);
      if ($urandom_range(15) == 0) begin w = -int'($urandom_range(3)); h = 0; end
      it.r = coord_t'(near_coord(it.l, 0) + w);
      it.t = coord_t'(near_coord(it.b, 0) + h);
      if ($urandom_range(19) == 0) begin
        it.l = coord_t'($urandom); it.r = coord_t'($urandom);
        it.b = coord_t'($urandom); it.t = coord_t'($urandom);
      end
      it.id = id_t'((k % 4096) + 1);
      if ($urandom_range(31) == 0) it.id = id_t'($urandom_range(4096, 1));
      it.first = (k == 0) && mark_first;
      it.last = (k == n_obst - 1);
      pending_q.push_back(it);
    end
  endtask

  task automatic add_item(coord_t sx, sy, dx, dy, l, b, r, t, id_t id, logic f, la);
    obst_item_t it;
    it.sx = sx; it.sy = sy; it.dx = dx; it.dy = dy;
    it.l = l; it.b = b; it.r = r; it.t = t;
    it.id = id; it.first = f; it.last = la;
    pending_q.push_back(it);
  endtask

  // driver: falling edge
  always @(negedge clk) begin
    obst_item_t it;
    bit offer;
    if (rst_n) begin
      offer = (!in_valid || in_ready_q) && pending_q.size() > 0 &&
              (no_idle || $urandom_range(99) >= 11);
      if (offer) begin
        it = pending_q.pop_front();
        in_src_x <= it.sx; in_src_y <= it.sy; in_dst_x <= it.dx; in_dst_y <= it.dy;
        in_rect_left <= it.l; in_rect_bottom <= it.b;
        in_rect_right <= it.r; in_rect_top <= it.t;
        in_obstacle_id <= it.id; in_first_obstacle <= it.first;
        in_last_obstacle <= it.last;
        in_valid <= 1'b1;
      end else if (in_valid && in_ready_q) begin
        in_valid <= 1'b0;
      end
      out_ready <= !rx_hold && (no_idle || $urandom_range(99) >= 11);
    end
  end

  // monitor: rising edge
  always @(posedge clk) begin
    route_res_t exp_r;
    int idle_nxt;
    in_ready_q <= in_valid && in_ready;
    if (rst_n) begin
      idle_nxt = idle_cycles + 1;
      if (in_valid && in_ready) begin
        obst_item_t it;
        it.sx = in_src_x; it.sy = in_src_y; it.dx = in_dst_x; it.dy = in_dst_y;
        it.l = in_rect_left; it.b = in_rect_bottom;
        it.r = in_rect_right; it.t = in_rect_top;
        it.id = in_obstacle_id; it.first = in_first_obstacle; it.last = in_last_obstacle;
        expected_q.push_back(predict_routes(it));
        accepted <= accepted + 1;
        idle_nxt = 0;
      end
      if (out_valid && out_ready) begin
        idle_nxt = 0;
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $display("unexpected result, id %0h", out_echo_id);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_echo_id !== exp_r.id) report_mismatch("echo_id", out_echo_id, exp_r.id);
          if (out_hit_mask !== exp_r.mask) report_mismatch("hit_mask", out_hit_mask, exp_r.mask);
          if (out_count_p0 !== exp_r.cnt[0]) report_mismatch("count_p0", out_count_p0, exp_r.cnt[0]);
          if (out_count_p1 !== exp_r.cnt[1]) report_mismatch("count_p1", out_count_p1, exp_r.cnt[1]);
          if (out_count_p2 !== exp_r.cnt[2]) report_mismatch("count_p2", out_count_p2, exp_r.cnt[2]);
          if (out_count_p3 !== exp_r.cnt[3]) report_mismatch("count_p3", out_count_p3, exp_r.cnt[3]);
          if (out_free_pattern !== exp_r.freep)
            report_mismatch("free_pattern", out_free_pattern, exp_r.freep);
          if (out_free_found !== exp_r.freef)
            report_mismatch("free_found", out_free_found, exp_r.freef);
          if (out_done_res !== exp_r.done) report_mismatch("done_res", out_done_res, exp_r.done);
        end
      end
      idle_cycles <= idle_nxt;
      if (idle_nxt > 5000) begin
        $display("watchdog: no handshake for %0d cycles", idle_nxt);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // long receiver hold-off, once, after the random part is under way
  initial begin
    wait (accepted >= 400);
    rx_hold = 1;
    repeat (300) @(posedge clk);
    rx_hold = 0;
  end

  // stretch with no idling on either side
  initial begin
    wait (accepted >= 900);
    no_idle = 1;
    wait (accepted >= 1200);
    no_idle = 0;
  end

  initial begin
    coord_t mx;
    mx = 20'hFFFFF;
    for (int p = 0; p < 4; p++) hit_cnt[p] = '0;
    // directed: extremes, straight and diagonal routes, degenerate shapes
    add_item(0, 0, mx, mx, 10, 10, 20, 20, 1, 1, 0);
    add_item(0, 0, mx, mx, 0, 0, mx, mx, 4096, 0, 0);
    add_item(100, 100, 300, 200, 150, 90, 180, 210, 2, 0, 0);
    add_item(300, 200, 100, 100, 240, 140, 260, 160, 3, 0, 0);
    add_item(100, 100, 200, 400, 120, 150, 130, 160, 4, 0, 0);
    add_item(100, 400, 200, 100, 195, 300, 205, 350, 5, 0, 0);
    add_item(100, 100, 200, 200, 140, 140, 160, 160, 6, 0, 0);
    add_item(100, 100, 100, 500, 90, 200, 110, 300, 7, 0, 0);
    add_item(100, 100, 500, 100, 200, 90, 300, 110, 8, 0, 0);
    add_item(50, 50, 50, 50, 40, 40, 60, 60, 9, 0, 0);
    add_item(100, 100, 200, 200, 160, 160, 150, 150, 10, 0, 0);
    add_item(100, 100, 200, 200, 150, 150, 150, 170, 11, 0, 0);
    add_item(100, 100, 200, 200, 300, 300, 400, 400, 12, 0, 0);
    add_item(100, 100, 200, 200, 100, 100, 200, 200, 13, 0, 1);
    add_item(mx, 0, 0, mx, 1, 1, coord_t'(mx - 1), coord_t'(mx - 1), 14, 1, 1);
    add_item(0, mx, mx, 0, 10, 10, 20, 20, 15, 0, 1);
    add_item(10, 10, 20, 20, 500, 500, 600, 600, 16, 1, 1);
    add_item(20'h55555, 20'hAAAAA, 20'hAAAAA, 20'h55555, 20'h55556, 20'h55556,
             20'hAAAA9, 20'hAAAA9, 13'h1555, 1, 0);
    add_item(20'hAAAAA, 20'h55555, 20'h55555, 20'hAAAAA, 20'h60000, 20'h60000,
             20'h70000, 20'h70000, 13'h0AAA, 0, 1);
    // long run on one route set, counts of the two diagonal routes climbing every item
    for (int k = 0; k < 300; k++)
      add_item(0, 0, 1000, 1000, 1, 1, 999, 999, id_t'(k + 1), k == 0, k == 299);
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    // sender pause until drained, then random nets
    repeat (5) @(posedge clk);
    for (int n = 0; n < 230; n++)
      add_net($urandom_range(12, 1), ($urandom_range(7) == 0) ? 400000 : $urandom_range(64, 4),
              $urandom_range(3) != 0, $urandom_range(19) != 0);
    wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d items, %0d results: directed shapes, a long counting run,",
             accepted, results_seen);
    $display("random nets, a receiver stall and a full drain");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end
endmodule

// ===== files.f =====
+incdir+src
src/orc_pkg.sv
src/orc_pattern.sv
src/octilinear_route_obstacle_check.sv
tb/tb_top.sv
